/* src/sdc_pkg.sv */
// ----------------------------------------------------------------------------
// SFP diagnostic sensor calibration package
// Shared types, constants and a float helper for the sensor calibration block.
// ----------------------------------------------------------------------------
package sdc_pkg;

  // Receive power polynomial: one cell per term above the constant.
  localparam int unsigned NumCoeff = 5;
  localparam int unsigned NumCells = NumCoeff - 1;

  // Pipeline depths of the float units and of one polynomial cell.
  localparam int unsigned MulLat  = 4;
  localparam int unsigned AddLat  = 5;
  localparam int unsigned CellLat = MulLat + AddLat;

  // Float encodings used at the edges of the datapath.
  localparam logic [31:0] FpQNaN   = 32'h7FC0_0000;
  localparam logic [30:0] FpInfMag = 31'h7F80_0000;
  localparam logic [30:0] FpMax16  = 31'h477F_FF00;  // 65535.0

  // Reciprocal of ten for a 16-bit dividend: (v * VoltRecip) >> VoltShift.
  localparam logic [16:0] VoltRecip = 17'd52429;
  localparam int unsigned VoltShift = 19;

  typedef enum logic [2:0] {
    ActTemp  = 3'd0,
    ActVolt  = 3'd1,
    ActBias  = 3'd2,
    ActTxPwr = 3'd3,
    ActRxPwr = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    RegDmi    = 3'd0,
    RegExtCal = 3'd1,
    RegCoeff0 = 3'd2,
    RegCoeff1 = 3'd3,
    RegCoeff2 = 3'd4,
    RegCoeff3 = 3'd5,
    RegCoeff4 = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0]         action;
    logic [15:0]        raw_sample;
    logic [15:0]        slope;
    logic signed [15:0] offset;
  } item_t;

  typedef struct packed {
    logic signed [17:0] sensor_value;
    logic               ok;
  } result_t;

  // Class of an unrounded float result.
  typedef enum logic [1:0] {
    FpNum,
    FpZero,
    FpInf,
    FpNan
  } fp_class_e;

  // Unrounded float: sig is an exact significand, bexp the biased exponent
  // that bit 47 of sig carries.
  typedef struct packed {
    fp_class_e          cls;
    logic               sign;
    logic [47:0]        sig;
    logic signed [10:0] bexp;
  } fp_raw_t;

  // Unpacked operand; subnormals use an exponent of one and no hidden bit.
  typedef struct packed {
    logic        sign;
    logic [7:0]  exp;
    logic [23:0] man;
    logic        is_zero;
    logic        is_inf;
    logic        is_nan;
  } fp_unp_t;

  // Per-item data that rides alongside the polynomial.
  typedef struct packed {
    logic        is_poly;
    logic        good;
    logic [17:0] value;
  } tok_t;

  // Everything one cell hands to the next.
  typedef struct packed {
    tok_t        tok;
    logic [31:0] x;
    logic [31:0] pw;
    logic [31:0] sum;
  } link_t;

  function automatic fp_unp_t fp_unpack(logic [31:0] f);
    fp_unp_t u;
    u.sign    = f[31];
    u.is_nan  = (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
    u.is_inf  = (f[30:23] == 8'hFF) && (f[22:0] == 23'd0);
    u.is_zero = (f[30:0] == 31'd0);
    u.exp     = (f[30:23] == 8'd0) ? 8'd1 : f[30:23];
    u.man     = {(f[30:23] != 8'd0), f[22:0]};
    return u;
  endfunction

endpackage

/* src/sdc_fround.sv */
// ----------------------------------------------------------------------------
// Float normalize and round
// Three-stage back end shared by the float units: byte normalize, bit
// normalize, then round to nearest even with subnormal and overflow handling.
// ----------------------------------------------------------------------------
module sdc_fround (
  input  logic            clk_i,
  input  sdc_pkg::fp_raw_t raw_i,
  output logic [31:0]     res_o
);
  import sdc_pkg::*;

  fp_raw_t            s1_d, s1_q, s2_d, s2_q;
  logic [2:0]         nbytes, nbits;
  logic               denorm, ovf, grd, stk, up;
  logic signed [10:0] sh;
  logic [5:0]         shc;
  logic [95:0]        wide;
  logic [23:0]        man;
  logic [7:0]         ef;
  logic [30:0]        mag;
  logic [31:0]        res_d, res_q;

  // Coarse normalize: drop whole leading zero bytes.
  always_comb begin
    nbytes = 3'd5;
    for (int i = 4; i >= 0; i--) begin
      if (raw_i.sig[47-8*i -: 8] != 8'h00) begin
        nbytes = 3'(i);
      end
    end
    s1_d      = raw_i;
    s1_d.sig  = raw_i.sig << {nbytes, 3'b000};
    s1_d.bexp = raw_i.bexp - 11'({nbytes, 3'b000});
  end

  // Fine normalize: bring the leading one to bit 47.
  always_comb begin
    nbits = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (s1_q.sig[47-i]) begin
        nbits = 3'(i);
      end
    end
    s2_d      = s1_q;
    s2_d.sig  = s1_q.sig << nbits;
    s2_d.bexp = s1_q.bexp - 11'(nbits);
  end

  // Round to nearest even; results below the normal range shift right first.
  always_comb begin
    denorm = (s2_q.bexp <= 11'sd0);
    ovf    = !denorm && (s2_q.bexp >= 11'sd255);
    sh     = 11'sd1 - s2_q.bexp;
    if (!denorm) begin
      shc = 6'd0;
    end else if (sh > 11'sd49) begin
      shc = 6'd49;
    end else begin
      shc = sh[5:0];
    end
    wide = {s2_q.sig, 48'd0} >> shc;
    man  = wide[95:72];
    grd  = wide[71];
    stk  = |wide[70:0];
    ef   = denorm ? 8'd0 : s2_q.bexp[7:0];
    up   = grd & (stk | man[0]);
    // A carry out of the fraction moves into the exponent field by itself.
    mag  = {ef, man[22:0]} + 31'(up);
    unique case (s2_q.cls)
      FpNan:   res_d = FpQNaN;
      FpInf:   res_d = {s2_q.sign, FpInfMag};
      FpZero:  res_d = {s2_q.sign, 31'd0};
      FpNum:   res_d = ovf ? {s2_q.sign, FpInfMag} : {s2_q.sign, mag};
      default: res_d = FpQNaN;
    endcase
  end

  always_ff @(posedge clk_i) begin
    s1_q  <= s1_d;
    s2_q  <= s2_d;
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

/* src/sdc_fmul.sv */
// ----------------------------------------------------------------------------
// Float multiplier
// Single-precision multiply: one stage for the significand product, then the
// shared normalize and round back end.
// ----------------------------------------------------------------------------
module sdc_fmul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] p_o
);
  import sdc_pkg::*;

  fp_unp_t ua, ub;
  fp_raw_t raw_d, raw_q;

  // Special operands and the exact product.
  always_comb begin
    ua         = fp_unpack(a_i);
    ub         = fp_unpack(b_i);
    raw_d.sign = ua.sign ^ ub.sign;
    raw_d.sig  = 48'(ua.man) * 48'(ub.man);
    raw_d.bexp = 11'(ua.exp) + 11'(ub.exp) - 11'sd126;
    if (ua.is_nan || ub.is_nan || (ua.is_inf && ub.is_zero) ||
        (ub.is_inf && ua.is_zero)) begin
      raw_d.cls = FpNan;
    end else if (ua.is_inf || ub.is_inf) begin
      raw_d.cls = FpInf;
    end else if (ua.is_zero || ub.is_zero) begin
      raw_d.cls = FpZero;
    end else begin
      raw_d.cls = FpNum;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q <= raw_d;
  end

  sdc_fround u_round (
    .clk_i (clk_i),
    .raw_i (raw_q),
    .res_o (p_o)
  );

endmodule

/* src/sdc_fadd.sv */
// ----------------------------------------------------------------------------
// Float adder
// Single-precision add: compare and swap, align and add with guard, round
// and sticky bits, then the shared normalize and round back end.
// ----------------------------------------------------------------------------
module sdc_fadd (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] s_o
);
  import sdc_pkg::*;

  typedef struct packed {
    fp_class_e   cls;
    logic        sign;
    logic        sub;
    logic [7:0]  exp;
    logic [23:0] man_big;
    logic [23:0] man_small;
    logic [7:0]  diff;
  } add_s1_t;

  fp_unp_t     ua, ub, ubig, usmall;
  add_s1_t     s1_d, s1_q;
  logic [4:0]  dd;
  logic [53:0] wide;
  logic [26:0] aligned, big;
  logic [27:0] sum;
  fp_raw_t     raw_d, raw_q;

  // Order the operands by magnitude and sort out the special cases.
  always_comb begin
    ua     = fp_unpack(a_i);
    ub     = fp_unpack(b_i);
    ubig   = (a_i[30:0] >= b_i[30:0]) ? ua : ub;
    usmall = (a_i[30:0] >= b_i[30:0]) ? ub : ua;
    s1_d.sub       = ua.sign ^ ub.sign;
    s1_d.exp       = ubig.exp;
    s1_d.man_big   = ubig.man;
    s1_d.man_small = usmall.man;
    s1_d.diff      = ubig.exp - usmall.exp;
    s1_d.sign      = ubig.sign;
    if (ua.is_nan || ub.is_nan || (ua.is_inf && ub.is_inf && s1_d.sub)) begin
      s1_d.cls = FpNan;
    end else if (ua.is_inf || ub.is_inf) begin
      s1_d.cls  = FpInf;
      s1_d.sign = ua.is_inf ? ua.sign : ub.sign;
    end else if (ua.is_zero && ub.is_zero) begin
      s1_d.cls  = FpZero;
      s1_d.sign = ua.sign & ub.sign;
    end else begin
      s1_d.cls = FpNum;
    end
  end

  // Align the smaller operand and add or subtract.
  always_comb begin
    dd      = (s1_q.diff > 8'd27) ? 5'd27 : s1_q.diff[4:0];
    wide    = {s1_q.man_small, 3'b000, 27'd0} >> dd;
    aligned = {wide[53:28], wide[27] | (|wide[26:0])};
    big     = {s1_q.man_big, 3'b000};
    sum     = s1_q.sub ? ({1'b0, big} - {1'b0, aligned}) : ({1'b0, big} + {1'b0, aligned});
    raw_d.sig  = {sum, 20'd0};
    raw_d.bexp = 11'(s1_q.exp) + 11'sd1;
    raw_d.sign = s1_q.sign;
    raw_d.cls  = s1_q.cls;
    // Exact cancellation gives positive zero.
    if (s1_q.cls == FpNum && sum == 28'd0) begin
      raw_d.cls  = FpZero;
      raw_d.sign = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q  <= s1_d;
    raw_q <= raw_d;
  end

  sdc_fround u_round (
    .clk_i (clk_i),
    .raw_i (raw_q),
    .res_o (s_o)
  );

endmodule

/* src/sdc_cell.sv */
// ----------------------------------------------------------------------------
// Polynomial cell
// One term of the receive power polynomial: the next power of x and the
// scaled term are formed in parallel, then the term joins the running sum.
// ----------------------------------------------------------------------------
module sdc_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [31:0]    coeff_i,
  input  logic           valid_i,
  input  sdc_pkg::link_t link_i,
  output logic           valid_o,
  output sdc_pkg::link_t link_o
);
  import sdc_pkg::*;

  logic [31:0]        pw_next, term, sum_next;
  logic [31:0]        sum_q [MulLat];
  logic [31:0]        pw_q  [AddLat];
  logic [31:0]        x_q   [CellLat];
  tok_t               tok_q [CellLat];
  logic [CellLat-1:0] valid_q;

  // Next power of x and this cell's term.
  sdc_fmul u_mul_pw (
    .clk_i (clk_i),
    .a_i   (link_i.pw),
    .b_i   (link_i.x),
    .p_o   (pw_next)
  );

  sdc_fmul u_mul_term (
    .clk_i (clk_i),
    .a_i   (coeff_i),
    .b_i   (link_i.pw),
    .p_o   (term)
  );

  // The running sum waits for the term, then they are added.
  sdc_fadd u_add (
    .clk_i (clk_i),
    .a_i   (sum_q[MulLat-1]),
    .b_i   (term),
    .s_o   (sum_next)
  );

  // Delay lines keeping the other fields in step with the float units.
  always_ff @(posedge clk_i) begin
    sum_q[0] <= link_i.sum;
    for (int i = 1; i < MulLat; i++) begin
      sum_q[i] <= sum_q[i-1];
    end
    pw_q[0] <= pw_next;
    for (int i = 1; i < AddLat; i++) begin
      pw_q[i] <= pw_q[i-1];
    end
    x_q[0]   <= link_i.x;
    tok_q[0] <= link_i.tok;
    for (int i = 1; i < CellLat; i++) begin
      x_q[i]   <= x_q[i-1];
      tok_q[i] <= tok_q[i-1];
    end
  end

  // Item valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[CellLat-2:0], valid_i};
    end
  end

  assign valid_o    = valid_q[CellLat-1];
  assign link_o.tok = tok_q[CellLat-1];
  assign link_o.x   = x_q[CellLat-1];
  assign link_o.pw  = pw_q[AddLat-1];
  assign link_o.sum = sum_next;

endmodule

/* src/sfp_dmi_sensor_calibration.sv */
// ----------------------------------------------------------------------------
// SFP diagnostic sensor calibration
// Converts one raw diagnostic sample into a reported sensor value, with
// linear external calibration and a float receive power polynomial.
// ----------------------------------------------------------------------------
// One item is taken in every clock cycle and busy_o stays low. Each result
// strobe is registered at the end of the pipeline below, in the order
// the items came in; the result is shown for that single cycle and cannot be
// held off, so the receiver must take it then. The path runs through four
// polynomial cells of nine stages each (two float multiplies side by side,
// then a float add), behind four front stages that register the item, form
// the linear product, calibrate and scale. Configuration writes are always
// ready and should only be issued while no item is in flight.
module sfp_dmi_sensor_calibration (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  sdc_pkg::item_t   item_i,
  output logic             result_valid_o,
  output sdc_pkg::result_t result_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [2:0]       cfg_index_i,
  input  logic [31:0]      cfg_data_i
);
  import sdc_pkg::*;

  // Configuration registers.
  logic        dmi_q, extcal_q;
  logic [31:0] coeff_q [NumCoeff];

  // Front pipeline.
  logic               a_valid_q;
  item_t              a_item_q;
  logic               b_valid_q;
  logic [2:0]         b_action_q;
  logic [15:0]        b_raw_q;
  logic signed [15:0] b_offset_q;
  logic signed [16:0] b_x_q, x17;
  logic signed [33:0] b_prod_q, prod;
  logic [31:0]        b_xf_q, xf;
  logic [4:0]         lz;
  logic [15:0]        rawn;
  logic               c_valid_q;
  logic [2:0]         c_action_q;
  logic [15:0]        c_raw_q;
  logic signed [16:0] c_v_q, v_d;
  logic [31:0]        c_xf_q;
  logic signed [33:0] prod_adj;
  logic signed [26:0] cal;
  logic               d_valid_q;
  tok_t               d_tok_q, tok_d;
  logic [31:0]        d_xf_q;
  logic signed [20:0] t10, t10_adj;
  logic [32:0]        vm;

  // Cell chain and output.
  logic               lvalid [NumCells+1];
  link_t              link   [NumCells+1];
  tok_t               fin;
  logic [31:0]        fsum;
  logic [7:0]         fsh;
  logic [23:0]        fman;
  logic [15:0]        fint;
  logic               good_d;
  logic [17:0]        value_d;
  logic               res_valid_q;
  result_t            res_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dmi_q    <= 1'b0;
      extcal_q <= 1'b0;
      for (int i = 0; i < NumCoeff; i++) begin
        coeff_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegDmi:    dmi_q      <= cfg_data_i[0];
        RegExtCal: extcal_q   <= cfg_data_i[0];
        RegCoeff0: coeff_q[0] <= cfg_data_i;
        RegCoeff1: coeff_q[1] <= cfg_data_i;
        RegCoeff2: coeff_q[2] <= cfg_data_i;
        RegCoeff3: coeff_q[3] <= cfg_data_i;
        RegCoeff4: coeff_q[4] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Linear product and the sample as a float.
  always_comb begin
    x17  = (a_item_q.action == ActTemp) ? {a_item_q.raw_sample[15], a_item_q.raw_sample}
                                        : {1'b0, a_item_q.raw_sample};
    prod = 34'(x17) * 34'($signed({1'b0, a_item_q.slope}));
    // The highest set bit decides the leading zero count.
    lz   = 5'd0;
    for (int i = 0; i < 16; i++) begin
      if (a_item_q.raw_sample[i]) begin
        lz = 5'(15 - i);
      end
    end
    rawn = a_item_q.raw_sample << lz[3:0];
    if (a_item_q.raw_sample == 16'd0) begin
      xf = 32'd0;
    end else begin
      xf = {1'b0, 8'd142 - 8'(lz), rawn[14:0], 8'd0};
    end
  end

  // Calibrate with truncation toward zero and saturate.
  always_comb begin
    prod_adj = b_prod_q + (b_prod_q[33] ? 34'sd255 : 34'sd0);
    cal      = 27'(prod_adj >>> 8) + 27'(b_offset_q);
    if (!extcal_q) begin
      v_d = b_x_q;
    end else if (b_action_q == ActTemp) begin
      if (cal > 27'sd32767) begin
        v_d = 17'sd32767;
      end else if (cal < -27'sd32768) begin
        v_d = -17'sd32768;
      end else begin
        v_d = 17'(cal);
      end
    end else begin
      if (cal > 27'sd65535) begin
        v_d = 17'sd65535;
      end else if (cal < 27'sd0) begin
        v_d = 17'sd0;
      end else begin
        v_d = 17'(cal);
      end
    end
  end

  // Reporting scale per sensor kind.
  always_comb begin
    t10     = (21'(c_v_q) <<< 3) + (21'(c_v_q) <<< 1);
    t10_adj = t10 + (t10[20] ? 21'sd255 : 21'sd0);
    vm      = 33'(c_v_q[15:0]) * 33'(VoltRecip);
    tok_d.is_poly = 1'b0;
    tok_d.good    = dmi_q;
    tok_d.value   = 18'd0;
    unique case (action_e'(c_action_q))
      ActTemp:  tok_d.value = 18'(t10_adj >>> 8);
      ActVolt:  tok_d.value = 18'(vm >> VoltShift);
      ActBias:  tok_d.value = {1'b0, c_v_q[15:0], 1'b0};
      ActTxPwr: tok_d.value = {2'b00, c_v_q[15:0]};
      ActRxPwr: begin
        tok_d.good    = 1'b1;
        tok_d.is_poly = extcal_q;
        tok_d.value   = {2'b00, c_raw_q};
      end
      default:  tok_d.good = 1'b0;
    endcase
  end

  // Front stage registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_item_q <= item_i;
    end
    b_action_q <= a_item_q.action;
    b_raw_q    <= a_item_q.raw_sample;
    b_offset_q <= a_item_q.offset;
    b_x_q      <= x17;
    b_prod_q   <= prod;
    b_xf_q     <= xf;
    c_action_q <= b_action_q;
    c_raw_q    <= b_raw_q;
    c_v_q      <= v_d;
    c_xf_q     <= b_xf_q;
    d_tok_q    <= tok_d;
    d_xf_q     <= c_xf_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      a_valid_q <= start_i && !busy_o;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      d_valid_q <= c_valid_q;
    end
  end

  // The polynomial starts with x as the first power and c0 as the sum.
  assign lvalid[0]   = d_valid_q;
  assign link[0].tok = d_tok_q;
  assign link[0].x   = d_xf_q;
  assign link[0].pw  = d_xf_q;
  assign link[0].sum = coeff_q[0];

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    sdc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .coeff_i (coeff_q[g+1]),
      .valid_i (lvalid[g]),
      .link_i  (link[g]),
      .valid_o (lvalid[g+1]),
      .link_o  (link[g+1])
    );
  end

  // Turn the float sum into an integer reading, or pass the linear result.
  always_comb begin
    fin     = link[NumCells].tok;
    fsum    = link[NumCells].sum;
    fsh     = 8'd150 - fsum[30:23];
    fman    = {1'b1, fsum[22:0]};
    fint    = 16'(fman >> fsh[4:0]);
    good_d  = fin.good;
    value_d = fin.value;
    if (fin.is_poly) begin
      if (fsum[30:23] == 8'hFF && fsum[22:0] != 23'd0) begin
        value_d = 18'd0;
      end else if (fsum[31]) begin
        value_d = 18'd0;
      end else if (fsum[30:0] > FpMax16) begin
        good_d = 1'b0;
      end else if (fsum[30:23] < 8'd127) begin
        value_d = 18'd0;
      end else begin
        value_d = {2'b00, fint};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.ok           <= good_d;
    res_q.sensor_value <= good_d ? value_d : '1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= lvalid[NumCells];
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

/* verif/tb_sfp_dmi_sensor_calibration.sv */
// ----------------------------------------------------------------------------
// Testbench for the SFP diagnostic sensor calibration block
// Drives the sensor items through several calibration settings. A scoreboard
// predicts each reported value, including the single-precision receive power
// polynomial, and checks every result strobe in order.
// ----------------------------------------------------------------------------
module tb_sfp_dmi_sensor_calibration;
  timeunit 1ns;
  timeprecision 1ps;
  import sdc_pkg::*;

  localparam logic [31:0] F_ONE   = 32'h3F80_0000;
  localparam logic [31:0] F_HALF  = 32'h3F00_0000;
  localparam logic [31:0] F_NEG5  = 32'hC0A0_0000;
  localparam logic [31:0] F_65535 = 32'h477F_FF00;
  localparam logic [31:0] F_QNAN  = 32'h7FC0_0000;
  localparam logic [31:0] F_PINF  = 32'h7F80_0000;
  localparam logic [31:0] F_NINF  = 32'hFF80_0000;

  logic    clk_i;
  logic    rst_ni;
  logic    start_i;
  logic    busy_o;
  item_t   item_i;
  logic    result_valid_o;
  result_t result_o;
  logic    cfg_valid_i;
  logic    cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  bit idle_on;
  int n_items;

  sfp_dmi_sensor_calibration u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // Single-precision bits to a real value.
  function automatic real sp_to_real(logic [31:0] b);
    logic [7:0] e;
    real r;
    e = b[30:23];
    if (e == 8'hFF) return $bitstoreal({b[31], 11'h7FF, b[22:0], 29'd0});
    if (e == 8'd0) begin
      r = real'(b[22:0]) * (2.0 ** -149.0);
      return b[31] ? -r : r;
    end
    return $bitstoreal({b[31], 11'(int'(e) + 896), b[22:0], 29'd0});
  endfunction

  // Real value to single precision, round to nearest even. A double holds any
  // product of two singles exactly, and rounding a double sum once more is
  // still correct for single-precision operands.
  function automatic logic [31:0] real_to_sp(real r);
    logic [63:0] d, sig, k, rem, half, val;
    int es, sh;
    d = $realtobits(r);
    if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? F_QNAN : {d[63], 31'h7F80_0000};
    if (d[62:52] == 11'd0) return {d[63], 31'd0};
    es = int'(d[62:52]) - 896;
    if (es >= 255) return {d[63], 31'h7F80_0000};
    sig = {11'd0, 1'b1, d[51:0]};
    sh = (es >= 1) ? 29 : 30 - es;
    if (sh > 54) return {d[63], 31'd0};
    k    = sig >> sh;
    rem  = sig & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && k[0])) k = k + 1;
    val = (es >= 1) ? ((64'(es - 1) << 23) + k) : k;
    if (val >= 64'h7F80_0000) val = 64'h7F80_0000;
    return {d[63], val[30:0]};
  endfunction

  // Predicts the reported value of each item and checks result strobes.
  class calib_scoreboard;
    bit          dmi_en;
    bit          ext_cal;
    logic [31:0] coeff [5];
    result_t     expected_q [$];
    int          errors;
    int          checked;

    function void set_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        RegDmi:    dmi_en  = data[0];
        RegExtCal: ext_cal = data[0];
        default:   if (idx <= RegCoeff4) coeff[idx - RegCoeff0] = data;
      endcase
    endfunction

    // Receive power through the rounded polynomial; returns 0 on failure.
    function bit rx_poly_reading(logic [15:0] raw, output longint v);
      logic [31:0] pw, term, acc;
      real s;
      if (!ext_cal) begin
        v = raw;
        return 1;
      end
      pw  = F_ONE;
      acc = coeff[0];
      for (int i = 1; i < 5; i++) begin
        pw   = real_to_sp(sp_to_real(pw) * real'(raw));
        term = real_to_sp(sp_to_real(coeff[i]) * sp_to_real(pw));
        acc  = real_to_sp(sp_to_real(acc) + sp_to_real(term));
      end
      v = 0;
      if (acc[30:23] == 8'hFF && acc[22:0] != 0) return 1;
      s = sp_to_real(acc);
      if (s > 65535.0) return 0;
      if (s > 0.0) v = $rtoi(s);
      return 1;
    endfunction

    function void note_item(item_t it);
      longint x, rep;
      bit good;
      result_t r;
      good = 0;
      rep  = -1;
      if (it.action <= ActTxPwr) begin
        if (dmi_en) begin
          good = 1;
          x = (it.action == ActTemp) ? longint'($signed(it.raw_sample))
                                     : longint'(it.raw_sample);
          if (ext_cal) begin
            x = x * longint'(it.slope) / 256 + longint'(it.offset);
            if (it.action == ActTemp) begin
              if (x > 32767) x = 32767;
              else if (x < -32768) x = -32768;
            end else begin
              if (x > 65535) x = 65535;
              else if (x < 0) x = 0;
            end
          end
          case (it.action)
            ActTemp: rep = x * 10 / 256;
            ActVolt: rep = x / 10;
            ActBias: rep = x * 2;
            default: rep = x;
          endcase
        end
      end else if (it.action == ActRxPwr) begin
        good = rx_poly_reading(it.raw_sample, x);
        if (good) rep = x;
      end
      if (!good) rep = -1;
      r.sensor_value = rep[17:0];
      r.ok = good;
      expected_q.push_back(r);
    endfunction

    function void check(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result value=%0d ok=%0b", $time,
                 got.sensor_value, got.ok);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.sensor_value !== want.sensor_value) begin
        $display("%0t: sensor_value expected %0d actual %0d", $time,
                 want.sensor_value, got.sensor_value);
        errors++;
      end
      if (got.ok !== want.ok) begin
        $display("%0t: ok expected %0b actual %0b", $time, want.ok, got.ok);
        errors++;
      end
    endfunction
  endclass

  calib_scoreboard calib_sb = new();

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watch accepted items and result strobes.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) calib_sb.note_item(item_i);
      if (result_valid_o) calib_sb.check(result_o);
    end
  end

  // Hard limit on the run.
  initial begin
    #2_000_000;
    $display("tb_sfp_dmi_sensor_calibration: done, errors");
    $finish;
  end

  // Writes one register through the configuration channel, then idles the channel.
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    calib_sb.set_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offers one item, at times with a random idle burst ahead of it.
  task automatic send_item(item_t it);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= it;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    n_items++;
  endtask

  // Lets every outstanding result arrive, then a short margin.
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (calib_sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (45) @(posedge clk_i);
  endtask

  function automatic item_t mk(logic [2:0] a, logic [15:0] r, logic [15:0] s,
                               logic [15:0] o);
    item_t it;
    it.action = a;
    it.raw_sample = r;
    it.slope = s;
    it.offset = o;
    return it;
  endfunction

  // Random field with extra weight on the edges.
  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      4:       return 16'($urandom_range(0, 600));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic item_t rand_item();
    logic [2:0] a;
    logic [15:0] s;
    a = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                     : 3'($urandom_range(0, 4));
    // Slopes cluster near unity as real modules use them.
    s = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(200, 320)) : pick16();
    return mk(a, pick16(), s, pick16());
  endfunction

  task automatic set_coeffs(logic [31:0] c0, logic [31:0] c1, logic [31:0] c2,
                            logic [31:0] c3, logic [31:0] c4);
    write_reg(RegCoeff0, c0);
    write_reg(RegCoeff1, c1);
    write_reg(RegCoeff2, c2);
    write_reg(RegCoeff3, c3);
    write_reg(RegCoeff4, c4);
  endtask

  // Main sequence.
  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    item_i      = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    idle_on     = 1'b1;
    n_items     = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: ;  // Reset settings: diagnostics off, calibration off.
        1: write_reg(RegDmi, 32'd1);
        2: begin
          write_reg(RegExtCal, 32'd1);
          set_coeffs(F_65535, F_ONE, 32'd0, 32'd0, 32'd0);
        end
        3: begin
          write_reg(RegDmi, 32'hFFFF_FFFE);
          set_coeffs($urandom, $urandom, $urandom, $urandom, $urandom);
        end
        4: begin
          write_reg(RegDmi, 32'hFFFF_FFFF);
          set_coeffs(F_HALF, 32'h3F7D_70A4, 32'h3727_C5AC, 32'h2F89_705F,
                     32'h2A5C_AC1F);
        end
        5: set_coeffs(F_QNAN, F_ONE, 32'd0, 32'd0, 32'd0);
        6: set_coeffs(F_NEG5, 32'h3F40_0000, 32'hB5A7_C5AC, 32'd0, 32'd0);
        7: set_coeffs(F_PINF, F_NINF, 32'h0000_0001, 32'h8000_0000, 32'd0);
        8: begin
          write_reg(RegExtCal, 32'hFFFF_FFFE);
          set_coeffs($urandom, $urandom, $urandom, $urandom, $urandom);
        end
        default: begin
          write_reg(RegExtCal, 32'd1);
          set_coeffs(32'h4120_0000, 32'h3E80_0000, 32'h3400_0000,
                     32'h2B00_0000, 32'h2000_0000);
          idle_on = 1'b0;
        end
      endcase

      // Field extremes and every action under the polynomial 65535 plus x.
      if (ph == 2) begin
        send_item(mk(ActTemp,  16'h8000, 16'hFFFF, 16'h8000));
        send_item(mk(ActTemp,  16'h7FFF, 16'hFFFF, 16'h7FFF));
        send_item(mk(ActTemp,  16'hFF00, 16'h0100, 16'h0000));
        send_item(mk(ActTemp,  16'hFFFF, 16'h0001, 16'h0000));
        send_item(mk(ActVolt,  16'hFFFF, 16'hFFFF, 16'h7FFF));
        send_item(mk(ActVolt,  16'h0000, 16'h0000, 16'h8000));
        send_item(mk(ActVolt,  16'h0009, 16'h0100, 16'h0000));
        send_item(mk(ActBias,  16'hFFFF, 16'h0100, 16'h0000));
        send_item(mk(ActBias,  16'h1234, 16'h0080, 16'hFFF0));
        send_item(mk(ActTxPwr, 16'hFFFF, 16'hFFFF, 16'h8000));
        send_item(mk(ActTxPwr, 16'h0001, 16'h0001, 16'h0000));
        send_item(mk(ActRxPwr, 16'h0000, 16'h0000, 16'h0000));
        send_item(mk(ActRxPwr, 16'h0001, 16'hFFFF, 16'hFFFF));
        send_item(mk(ActRxPwr, 16'hFFFF, 16'h0000, 16'h0000));
        send_item(mk(3'd5,     16'h1234, 16'h0100, 16'h0000));
        send_item(mk(3'd6,     16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_item(mk(3'd7,     16'h0000, 16'h0000, 16'h0000));
      end

      for (int i = 0; i < 65; i++) begin
        send_item(rand_item());
        // Hold off once mid-phase until everything has come back.
        if (ph == 4 && i == 30) begin
          start_i <= 1'b0;
          @(posedge clk_i);
          while (calib_sb.expected_q.size() != 0) @(posedge clk_i);
        end
      end
      drain();
    end

    $display("Sent %0d items over 10 calibration settings, %0d results checked.",
             n_items, calib_sb.checked);
    if (calib_sb.errors == 0 && calib_sb.expected_q.size() == 0) begin
      $display("tb_sfp_dmi_sensor_calibration: done, clean");
    end else begin
      $display("tb_sfp_dmi_sensor_calibration: done, errors");
    end
    $finish;
  end

endmodule
